// ===== rtl/ckr_pkg.sv =====
// ----------------------------------------------------------------------------
// ckr_pkg
// Shared types and constants of the chord keyboard remapper.
// ----------------------------------------------------------------------------
package ckr_pkg;

  localparam int CodeW  = 16;
  localparam int FlagsW = 3;
  localparam int ModeW  = 2;
  localparam int ActW   = 2;
  localparam int DirW   = 8;

  typedef logic [CodeW-1:0]  code_t;
  typedef logic [FlagsW-1:0] flags_t;
  typedef logic [ModeW-1:0]  mode_t;
  typedef logic [ActW-1:0]   act_t;
  typedef logic [DirW-1:0]   dir_t;

  // action codes
  localparam act_t ACT_PASS     = 2'd0;
  localparam act_t ACT_CONSUME  = 2'd1;
  localparam act_t ACT_PRESSREL = 2'd2;

  // key flag values, whole word compared
  localparam flags_t FLAG_MAKE  = 3'd0;
  localparam flags_t FLAG_BREAK = 3'd1;

  // row_mode codes
  localparam mode_t MODE_COMPAT = 2'd0;
  localparam mode_t MODE_BLOCK  = 2'd1;
  localparam mode_t MODE_REMAP  = 2'd2;

  // key ranges
  localparam code_t HOME_LO  = 16'h001E;
  localparam code_t HOME_HI  = 16'h0029;
  localparam code_t HOME_MID = 16'h0022;
  localparam code_t TOP_LO   = 16'h0010;
  localparam code_t TOP_HI   = 16'h001B;
  localparam code_t BOT_LO   = 16'h002B;
  localparam code_t BOT_HI   = 16'h0035;

  // row shifts
  localparam code_t SHIFT_UP   = 16'h000E;
  localparam code_t SHIFT_DOWN = 16'h000D;
  localparam code_t TOP_OFFSET = 16'h0009;

  typedef struct packed {
    act_t  action;
    code_t code;
  } result_t;

endpackage

// ===== rtl/ckr_event_if.sv =====
// ----------------------------------------------------------------------------
// ckr_event_if
// Key event channel: scan code and flags with valid/ready.
// ----------------------------------------------------------------------------
interface ckr_event_if;
  logic           valid;
  logic           ready;
  ckr_pkg::code_t  scan_code;
  ckr_pkg::flags_t key_flags;

  modport source (output valid, output scan_code, output key_flags, input ready);
  modport sink   (input valid, input scan_code, input key_flags, output ready);
endinterface

// ===== rtl/ckr_result_if.sv =====
// ----------------------------------------------------------------------------
// ckr_result_if
// Result channel: action and remapped code with valid/ready.
// ----------------------------------------------------------------------------
interface ckr_result_if;
  logic          valid;
  logic          ready;
  ckr_pkg::act_t  action;
  ckr_pkg::code_t out_code;

  modport source (output valid, output action, output out_code, input ready);
  modport sink   (input valid, input action, input out_code, output ready);
endinterface

// ===== rtl/ckr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ckr_cfg_if
// Configuration write channel carrying the row_mode register.
// ----------------------------------------------------------------------------
interface ckr_cfg_if;
  logic          valid;
  logic          ready;
  ckr_pkg::mode_t row_mode;

  modport source (output valid, output row_mode, input ready);
  modport sink   (input valid, input row_mode, output ready);
endinterface

// ===== rtl/ckr_row.sv =====
// ----------------------------------------------------------------------------
// ckr_row
// Top/bottom row handling: pass, consume or remap according to row_mode.
// ----------------------------------------------------------------------------
module ckr_row (
  input  ckr_pkg::mode_t   row_mode,
  input  ckr_pkg::code_t   code,
  output ckr_pkg::result_t res
);

  logic in_top;
  logic in_bot;

  assign in_top = (code >= ckr_pkg::TOP_LO) && (code <= ckr_pkg::TOP_HI);
  assign in_bot = (code >= ckr_pkg::BOT_LO) && (code <= ckr_pkg::BOT_HI);

  always_comb begin
    res.action = ckr_pkg::ACT_PASS;
    res.code   = code;
    if (in_top || in_bot) begin
      case (row_mode)
        ckr_pkg::MODE_BLOCK: begin
          res.action = ckr_pkg::ACT_CONSUME;
        end
        ckr_pkg::MODE_REMAP: begin
          if (in_top) begin
            res.code = code - ckr_pkg::TOP_OFFSET;
          end else begin
            case (code)
              16'h002B: res.code = 16'h002A;
              16'h002C: res.code = 16'h001D;
              16'h002D: res.code = 16'hE05B;
              16'h002E: res.code = 16'h0038;
              16'h0031: res.code = 16'hE038;
              16'h0032: res.code = 16'hE05C;
              16'h0033: res.code = 16'hE05D;
              16'h0034: res.code = 16'hE01D;
              16'h0035: res.code = 16'h0036;
              default:  res.action = ckr_pkg::ACT_CONSUME; // 0x2F, 0x30 unmapped
            endcase
          end
        end
        default: begin
          res.action = ckr_pkg::ACT_PASS;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ckr_chord.sv =====
// ----------------------------------------------------------------------------
// ckr_chord
// Home-row chord tracker: direction counter, last flags, press-release emit.
// ----------------------------------------------------------------------------
module ckr_chord (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  ckr_pkg::code_t   code,
  input  ckr_pkg::flags_t  flags,
  output logic             is_home,
  output ckr_pkg::result_t res
);

  ckr_pkg::dir_t   dir_r, dir_nxt;
  ckr_pkg::flags_t prev_r, prev_nxt;
  logic            lower;
  logic            is_make;
  logic            is_break;
  logic            emit;

  assign is_home  = (code >= ckr_pkg::HOME_LO) && (code <= ckr_pkg::HOME_HI);
  assign lower    = (code <= ckr_pkg::HOME_MID);
  assign is_make  = (flags == ckr_pkg::FLAG_MAKE);
  assign is_break = (flags == ckr_pkg::FLAG_BREAK);
  assign emit     = is_break && (prev_r == ckr_pkg::FLAG_MAKE);

  always_comb begin
    dir_nxt = dir_r;
    if ((!lower && is_make) || (lower && is_break)) begin
      dir_nxt = dir_r + 8'd1;
    end else if ((lower && is_make) || (!lower && is_break)) begin
      dir_nxt = dir_r - 8'd1;
    end
    prev_nxt = flags;
  end

  // result uses the counter after this event's update
  always_comb begin
    res.action = ckr_pkg::ACT_CONSUME;
    res.code   = code;
    if (emit) begin
      res.action = ckr_pkg::ACT_PRESSREL;
      if (dir_nxt != '0) begin
        res.code = dir_nxt[ckr_pkg::DirW-1] ? code + ckr_pkg::SHIFT_DOWN
                                             : code - ckr_pkg::SHIFT_UP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= '0;
      prev_r <= ckr_pkg::FLAG_BREAK;
    end else if (fire && is_home) begin
      dir_r  <= dir_nxt;
      prev_r <= prev_nxt;
    end
  end

`ifndef SYNTH
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(fire && is_home)) |=> ($stable(dir_r) && $stable(prev_r)))
    else $error("chord state changed without a home-row word");

  a_odd_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && fire && is_home && !is_make && !is_break) |=> $stable(dir_r))
    else $error("counter moved on a prefixed home-row word");

  a_emit_after_make: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_home && (res.action == ckr_pkg::ACT_PRESSREL)) |->
    (prev_r == ckr_pkg::FLAG_MAKE))
    else $error("press-release emitted without a preceding make");
`endif

endmodule

// ===== rtl/chord_keyboard_remapper.sv =====
// ----------------------------------------------------------------------------
// chord_keyboard_remapper
// Chording keyboard filter: home-row chords and top/bottom row remap.
// ----------------------------------------------------------------------------
// One key event word is taken per clock while in_ready is high and gives
// exactly one result word. A word sits in the input register, where the
// home-row chord counter and last-flags state are updated and the result
// is formed, then moves to the result register, which drives out_valid;
// a new word is accepted every cycle while the output is being taken.
// A stalled output holds both stages; in_ready drops only when both are full.
// row_mode is written through the cfg channel (always ready); the user is to
// write it only while idle, which the block itself does not enforce.
module chord_keyboard_remapper (
  input  logic                clk,
  input  logic                rst_n,
  ckr_event_if.sink           in_ch,
  ckr_result_if.source        out_ch,
  ckr_cfg_if.sink             cfg_ch
);

  ckr_pkg::mode_t   mode_r;
  logic             s1_v_r, s1_v_nxt;
  ckr_pkg::code_t   s1_code_r;
  ckr_pkg::flags_t  s1_flags_r;
  logic             s2_v_r, s2_v_nxt;
  ckr_pkg::result_t s2_res_r;

  logic             in_fire;
  logic             s2_load;
  logic             s1_adv;
  logic             is_home;
  ckr_pkg::result_t chord_res;
  ckr_pkg::result_t row_res;
  ckr_pkg::result_t sel_res;

  assign s2_load     = !s2_v_r || out_ch.ready;
  assign s1_adv      = s1_v_r && s2_load;
  assign in_ch.ready = !s1_v_r || s2_load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  ckr_chord u_chord (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_adv),
    .code    (s1_code_r),
    .flags   (s1_flags_r),
    .is_home (is_home),
    .res     (chord_res)
  );

  ckr_row u_row (
    .row_mode (mode_r),
    .code     (s1_code_r),
    .res      (row_res)
  );

  assign sel_res = is_home ? chord_res : row_res;

  always_comb begin
    s1_v_nxt = in_fire || (s1_v_r && !s2_load);
    s2_v_nxt = s1_adv || (s2_v_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ckr_pkg::MODE_COMPAT;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mode_r <= cfg_ch.row_mode;
      end
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_code_r  <= in_ch.scan_code;
      s1_flags_r <= in_ch.key_flags;
    end
    if (s1_adv) begin
      s2_res_r <= sel_res;
    end
  end

  assign out_ch.valid    = s2_v_r;
  assign out_ch.action   = s2_res_r.action;
  assign out_ch.out_code = s2_res_r.code;

`ifndef SYNTH
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && s1_adv) |=> s2_v_r)
    else $error("word left stage 1 but result register is empty");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && s1_v_r && !s2_load) |=>
    (s1_v_r && $stable(s1_code_r) && $stable(s1_flags_r)))
    else $error("stage 1 word lost during output stall");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cfg_ch.valid) |=> (mode_r == $past(cfg_ch.row_mode)))
    else $error("row_mode write not taken");
`endif

endmodule
